### hdl/morton_square_atlas_packer_assert.svh
// Assertion macros shared by the atlas packer RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef MORTON_SQUARE_ATLAS_PACKER_ASSERT_SVH
`define MORTON_SQUARE_ATLAS_PACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSAP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define MSAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MSAP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/msap_pkg.sv
// Shared types and constants for the atlas packer.
// Used by msap_cell, msap_chain and the top level; no dependencies.
`default_nettype none
package msap_pkg;

	localparam int MAX_TILES_DEF     = 64;
	localparam int MAX_SIDE_LOG2_DEF = 12;
	localparam int SIZE_W            = 4;
	localparam int KEY_W             = 25;
	localparam int TAG_W             = 6;
	localparam int COORD_W           = 12;
	localparam int ADDR_W            = 3;
	localparam logic [SIZE_W-1:0] MAX_SIDE_RESET = 4'd12;
	localparam logic [0:0] REG_MAX_SIDE = 1'b0;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
	} tile_t;

	typedef struct packed {
		logic  valid;
		tile_t tile;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		tile_t    tile;
	} chain_cmd_t;

endpackage
`default_nettype wire

### hdl/msap_cell.sv
// One slot of the sorted tile chain: holds a tile, compares it with the broadcast tile.
// Depends on msap_pkg.
`default_nettype none
module msap_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  msap_pkg::chain_cmd_t cmd,
	input  msap_pkg::entry_t    prev_ent,
	input  logic                prev_gt,
	input  msap_pkg::entry_t    next_ent,
	output msap_pkg::entry_t    ent,
	output logic                gt
);
	import msap_pkg::*;

	logic  vld_q;
	tile_t tile_q;

	// empty slots rank below everything, so the chain stays packed at the head
	always_comb begin
		gt = !vld_q || (cmd.tile > tile_q);
	end

	assign ent = '{valid: vld_q, tile: tile_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INSERT: begin
					if (gt) begin
						vld_q <= prev_gt ? prev_ent.valid : 1'b1;
					end
				end
				OP_SHIFT: vld_q <= next_ent.valid;
				OP_CLEAR: vld_q <= 1'b0;
				default:  vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (gt) begin
					tile_q <= prev_gt ? prev_ent.tile : cmd.tile;
				end
			end
			OP_SHIFT: tile_q <= next_ent.tile;
			default:  tile_q <= tile_q;
		endcase
	end

endmodule
`default_nettype wire

### hdl/msap_chain.sv
// Row of msap_cell slots forming a descending insertion sorter and shift-out queue.
// Depends on msap_pkg, msap_cell and the assertion header.
`default_nettype none
`include "morton_square_atlas_packer_assert.svh"
module msap_chain #(
	parameter int MAX_TILES = msap_pkg::MAX_TILES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msap_pkg::chain_cmd_t cmd,
	output msap_pkg::entry_t     head
);
	import msap_pkg::*;

	entry_t               ent      [MAX_TILES];
	entry_t               prev_ent [MAX_TILES];
	entry_t               next_ent [MAX_TILES];
	logic [MAX_TILES-1:0] gt_vec;
	logic [MAX_TILES-1:0] prev_gt;
	logic [MAX_TILES-1:0] vld_vec;

	for (genvar i = 0; i < MAX_TILES; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_ent[i] = '0;
			assign prev_gt[i]  = 1'b0;
		end else begin : g_inner
			assign prev_ent[i] = ent[i-1];
			assign prev_gt[i]  = gt_vec[i-1];
		end
		if (i == MAX_TILES - 1) begin : g_last
			assign next_ent[i] = '0;
		end else begin : g_mid
			assign next_ent[i] = ent[i+1];
		end
		assign vld_vec[i] = ent[i].valid;

		msap_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.prev_ent (prev_ent[i]),
			.prev_gt  (prev_gt[i]),
			.next_ent (next_ent[i]),
			.ent      (ent[i]),
			.gt       (gt_vec[i])
		);
	end

	assign head = ent[0];

	// occupied slots always form a contiguous run starting at the head
	`MSAP_ASSERT(a_valid_prefix, clk, arst_n, ((vld_vec & (vld_vec + 1'b1)) == '0), "chain has a gap")

endmodule
`default_nettype wire

### hdl/morton_square_atlas_packer.sv
// Top level: while busy is low, tiles load one per cycle into the sorted chain; after the
// tile marked last come a check state, a side search state, then one placement per cycle.
// An overflow result is registered in the check state, in place of any placements.
// busy stays high from the last tile to the final result; results cannot be stalled.
// Reset clears control state and the config register (12); tile payloads are not cleared.
`default_nettype none
`include "morton_square_atlas_packer_assert.svh"
module morton_square_atlas_packer #(
	parameter int MAX_TILES     = msap_pkg::MAX_TILES_DEF,
	parameter int MAX_SIDE_LOG2 = msap_pkg::MAX_SIDE_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [msap_pkg::SIZE_W-1:0]   size_log2,
	input  logic [msap_pkg::KEY_W-1:0]    tie_key,
	input  logic [msap_pkg::TAG_W-1:0]    tag,
	input  logic                          last,
	output logic                          result_valid,
	output logic [msap_pkg::TAG_W-1:0]    out_tag,
	output logic [msap_pkg::COORD_W-1:0]  left,
	output logic [msap_pkg::COORD_W-1:0]  top,
	output logic [msap_pkg::SIZE_W-1:0]   side_log2,
	output logic                          overflow,
	output logic                          out_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msap_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import msap_pkg::*;

	localparam int TW    = 2 * MAX_SIDE_LOG2 + 1;
	localparam int SW    = TW + 1;
	localparam int CNT_W = $clog2(MAX_TILES + 1);
	localparam logic [TW-1:0] CEIL = (TW'(1) << (2 * MAX_SIDE_LOG2)) + TW'(1);
	localparam logic [SIZE_W-1:0] MAX_SIDE = SIZE_W'(MAX_SIDE_LOG2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SIZE,
		ST_PLACE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [TW-1:0]       total_q;
	logic [TW-1:0]       placed_q;
	logic [SIZE_W-1:0]   side_q;
	logic [SIZE_W-1:0]   max_side_q;

	logic                result_valid_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [COORD_W-1:0]  left_q;
	logic [COORD_W-1:0]  top_q;
	logic [SIZE_W-1:0]   side_log2_q;
	logic                overflow_q;
	logic                out_last_q;

	logic                accept;
	logic                full;
	logic [SIZE_W-1:0]   eff;
	logic [TW-1:0]       cap;
	logic [TW-1:0]       pow;
	logic [SW-1:0]       add;
	logic [SW-1:0]       sum;
	logic [TW-1:0]       total_nx;
	chain_cmd_t          cmd;
	entry_t              head;
	logic [2*COORD_W-1:0] pl_lo;
	logic [COORD_W-1:0]  x12;
	logic [COORD_W-1:0]  y12;
	logic [COORD_W-1:0]  side12;
	logic [COORD_W-1:0]  tside12;
	logic [TW-1:0]       placed_nx;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_side_q <= MAX_SIDE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_SIDE) begin
			max_side_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_SIDE) begin
			prdata = 32'(max_side_q);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_TILES));

	// capacity, side search and saturating total
	always_comb begin
		eff = (max_side_q > MAX_SIDE) ? MAX_SIDE : max_side_q;
		cap = TW'(1) << {eff, 1'b0};
		pow = TW'(1) << {side_q, 1'b0};
		add = SW'(1) << {size_log2, 1'b0};
		if (size_log2 > MAX_SIDE) begin
			sum = {1'b0, CEIL};
		end else begin
			sum = {1'b0, total_q} + add;
		end
		total_nx = (sum > {1'b0, CEIL}) ? CEIL : sum[TW-1:0];
	end

	// chain command
	always_comb begin
		cmd.tile = '{size: size_log2, key: tie_key, tag: tag};
		cmd.op   = OP_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (accept && !full) begin
					cmd.op = OP_INSERT;
				end
			end
			ST_CHECK: begin
				if (total_q > cap) begin
					cmd.op = OP_CLEAR;
				end
			end
			ST_PLACE: cmd.op = OP_SHIFT;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	msap_chain #(
		.MAX_TILES (MAX_TILES)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head)
	);

	// Z-order position: even bits of the running placed area give x, odd bits y
	always_comb begin
		pl_lo = (2*COORD_W)'(placed_q);
		for (int i = 0; i < COORD_W; i++) begin
			x12[i] = pl_lo[2*i];
			y12[i] = pl_lo[2*i+1];
		end
		side12    = COORD_W'(1) << side_q;
		tside12   = COORD_W'(1) << head.tile.size;
		placed_nx = placed_q + (TW'(1) << {head.tile.size, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			total_q        <= '0;
			placed_q       <= '0;
			side_q         <= '0;
			result_valid_q <= 1'b0;
			out_tag_q      <= '0;
			left_q         <= '0;
			top_q          <= '0;
			side_log2_q    <= '0;
			overflow_q     <= 1'b0;
			out_last_q     <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// drop the tile when the chain is full, but honor its last mark
						if (!full) begin
							count_q <= count_q + 1'b1;
							total_q <= total_nx;
						end
						if (last) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (total_q > cap) begin
						result_valid_q <= 1'b1;
						out_tag_q      <= '0;
						left_q         <= '0;
						top_q          <= '0;
						side_log2_q    <= '0;
						overflow_q     <= 1'b1;
						out_last_q     <= 1'b1;
						count_q        <= '0;
						total_q        <= '0;
						state_q        <= ST_IDLE;
					end else begin
						side_q  <= '0;
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					if (pow < total_q) begin
						side_q <= side_q + 1'b1;
					end else begin
						placed_q <= '0;
						state_q  <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					result_valid_q <= 1'b1;
					out_tag_q      <= head.tile.tag;
					left_q         <= side12 - x12 - tside12;
					top_q          <= side12 - y12 - tside12;
					side_log2_q    <= side_q;
					overflow_q     <= 1'b0;
					out_last_q     <= (count_q == CNT_W'(1));
					placed_q       <= placed_nx;
					count_q        <= count_q - 1'b1;
					if (count_q == CNT_W'(1)) begin
						total_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign out_tag      = out_tag_q;
	assign left         = left_q;
	assign top          = top_q;
	assign side_log2    = side_log2_q;
	assign overflow     = overflow_q;
	assign out_last     = out_last_q;

	`MSAP_ASSERT(a_ovf_single, clk, arst_n, ((result_valid && overflow) |-> out_last), "overflow result not final")
	`MSAP_ASSERT(a_mid_busy, clk, arst_n, ((result_valid && !out_last) |-> busy), "run ended early")
	`MSAP_ASSERT(a_run_clear, clk, arst_n, ((result_valid && out_last) |-> (!busy && count_q == '0)), "run not cleared")
	`MSAP_ASSERT_NEXT(a_last_busy, clk, arst_n, (start && !busy && last), busy, "last tile did not start placement")

endmodule
`default_nettype wire

### verif/morton_square_atlas_packer_test.sv
// Self-checking testbench for morton_square_atlas_packer: tile sets in, Z-order placements out.
// Uses msap_pkg for widths, tile type and register index; needs only the RTL to build.
// A directed table runs first, then random tile sets under several max-side settings.
`default_nettype none
module morton_square_atlas_packer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import msap_pkg::*;

	localparam int          TILE_CAP   = MAX_TILES_DEF;
	localparam longint      AREA_CEIL  = (64'd1 << (2 * MAX_SIDE_LOG2_DEF)) + 1;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          DRAIN_WAIT = 24;
	localparam logic [ADDR_W-1:0] MAX_SIDE_ADDR = {REG_MAX_SIDE, 2'b00};

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [SIZE_W-1:0]  side_l;
		logic               overflow;
		logic               fin;
	} placement_t;

	typedef struct {
		tile_t      tile;
		bit         fin;
		bit         typed;
		placement_t want;
	} table_row_t;

	localparam placement_t OVERFLOW_RESULT = '{tag: '0, left: '0, top: '0, side_l: '0,
		overflow: 1'b1, fin: 1'b1};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [SIZE_W-1:0]   size_log2;
	logic [KEY_W-1:0]    tie_key;
	logic [TAG_W-1:0]    tag;
	logic                last;
	logic                result_valid;
	logic [TAG_W-1:0]    out_tag;
	logic [COORD_W-1:0]  left;
	logic [COORD_W-1:0]  top;
	logic [SIZE_W-1:0]   side_log2;
	logic                overflow;
	logic                out_last;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// predictor state
	tile_t        held_tiles[$];
	longint       area_sum;
	logic [3:0]   cap_side_log2;
	placement_t   fresh_q[$];
	placement_t   placement_q[$];
	table_row_t   directed[$];
	int           errors;
	int           cycles;

	morton_square_atlas_packer uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.size_log2(size_log2), .tie_key(tie_key), .tag(tag), .last(last),
		.result_valid(result_valid), .out_tag(out_tag), .left(left), .top(top),
		.side_log2(side_log2), .overflow(overflow), .out_last(out_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("morton_square_atlas_packer verification failed");
			$finish;
		end
	end

	// Load one tile into the predictor; on the last tile fill fresh_q with the placements.
	function automatic void pack_tile(input tile_t t, input bit fin);
		int unsigned eff;
		int unsigned sl;
		int          j;
		bit          above;
		tile_t       b;
		tile_t       sorted[$];
		longint      placed;
		longint      side;
		longint      tside;
		longint      x;
		longint      y;
		longint      coord;
		placement_t  p;
		fresh_q.delete();
		if (held_tiles.size() < TILE_CAP) begin
			held_tiles.insert(held_tiles.size(), t);
			area_sum += 64'd1 << (2 * t.size);
			if (area_sum > AREA_CEIL)
				area_sum = AREA_CEIL;
		end
		if (!fin)
			return;
		eff = (cap_side_log2 > MAX_SIDE_LOG2_DEF) ? MAX_SIDE_LOG2_DEF : cap_side_log2;
		if (area_sum > (64'd1 << (2 * eff))) begin
			fresh_q.insert(fresh_q.size(), OVERFLOW_RESULT);
		end else begin
			sl = 0;
			while ((64'd1 << (2 * sl)) < area_sum)
				sl++;
			side = 64'd1 << sl;
			// stable insertion: descending size, then key, then tag
			foreach (held_tiles[i]) begin
				j = sorted.size();
				while (j > 0) begin
					b = sorted[j-1];
					if (held_tiles[i].size != b.size)
						above = held_tiles[i].size > b.size;
					else if (held_tiles[i].key != b.key)
						above = held_tiles[i].key > b.key;
					else
						above = held_tiles[i].tag > b.tag;
					if (!above)
						break;
					j--;
				end
				sorted.insert(j, held_tiles[i]);
			end
			placed = 0;
			foreach (sorted[i]) begin
				tside = 64'd1 << sorted[i].size;
				x = 0;
				y = 0;
				for (int k = 0; k < 16; k++) begin
					x[k] = placed[2*k];
					y[k] = placed[2*k+1];
				end
				p.tag = sorted[i].tag;
				coord = side - x - tside;
				p.left = coord[COORD_W-1:0];
				coord = side - y - tside;
				p.top = coord[COORD_W-1:0];
				p.side_l = sl[SIZE_W-1:0];
				p.overflow = 1'b0;
				p.fin = (i == sorted.size() - 1);
				fresh_q.insert(fresh_q.size(), p);
				placed += tside * tside;
			end
		end
		held_tiles.delete();
		area_sum = 0;
	endfunction

	// Drive one tile after a gap, hold until accepted, then book its results.
	task automatic feed_tile(input tile_t t, input bit fin, input int gap, input bit typed,
			input placement_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		size_log2 <= t.size;
		tie_key <= t.key;
		tag <= t.tag;
		last <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pack_tile(t, fin);
		if (typed)
			placement_q.insert(placement_q.size(), want);
		else
			foreach (fresh_q[i])
				placement_q.insert(placement_q.size(), fresh_q[i]);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write the max-side register, then read it back in the next transaction.
	task automatic program_max_side(input logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_SIDE_ADDR;
		pwdata <= {28'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cap_side_log2 = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {28'd0, value}) begin
			$display("%0t: max_side_log2 readback expected %0d got %0d", $time, value, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_row(input logic [SIZE_W-1:0] sz, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tg, input bit fin, input bit typed, input placement_t want);
		table_row_t r;
		r.tile = '{size: sz, key: key, tag: tg};
		r.fin = fin;
		r.typed = typed;
		r.want = want;
		directed.insert(directed.size(), r);
	endtask

	always @(posedge clk) begin
		placement_t want;
		if (arst_n && result_valid) begin
			if (placement_q.size() == 0) begin
				$display("%0t: unexpected result expected none got tag %0d left %0d top %0d",
					$time, out_tag, left, top);
				errors++;
			end else begin
				want = placement_q.pop_front();
				if (out_tag !== want.tag) begin
					$display("%0t: out_tag expected %0d got %0d", $time, want.tag, out_tag);
					errors++;
				end
				if (left !== want.left) begin
					$display("%0t: left expected %0d got %0d", $time, want.left, left);
					errors++;
				end
				if (top !== want.top) begin
					$display("%0t: top expected %0d got %0d", $time, want.top, top);
					errors++;
				end
				if (side_log2 !== want.side_l) begin
					$display("%0t: side_log2 expected %0d got %0d", $time, want.side_l,
						side_log2);
					errors++;
				end
				if (overflow !== want.overflow) begin
					$display("%0t: overflow expected %0d got %0d", $time, want.overflow,
						overflow);
					errors++;
				end
				if (out_last !== want.fin) begin
					$display("%0t: out_last expected %0d got %0d", $time, want.fin, out_last);
					errors++;
				end
			end
		end
	end

	initial begin
		int          phase_items;
		int          n;
		int          smax;
		int          eff;
		bit          burst;
		bit          big_set;
		logic [3:0]  cfg;
		tile_t       t;
		arst_n = 1'b0;
		start = 1'b0;
		size_log2 = '0;
		tie_key = '0;
		tag = '0;
		last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		area_sum = 0;
		cap_side_log2 = MAX_SIDE_RESET;

		// single tiles at the size extremes, then overflow cases
		add_row(4'd2, 25'd0, 6'd0, 1, 1, '{tag: 6'd0, left: '0, top: '0, side_l: 4'd2,
			overflow: 1'b0, fin: 1'b1});
		add_row(4'd12, 25'h1FFFFFF, 6'd63, 1, 1, '{tag: 6'd63, left: '0, top: '0,
			side_l: 4'd12, overflow: 1'b0, fin: 1'b1});
		add_row(4'd0, 25'd1, 6'd5, 1, 1, '{tag: 6'd5, left: '0, top: '0, side_l: 4'd0,
			overflow: 1'b0, fin: 1'b1});
		add_row(4'd13, 25'h1555555, 6'd9, 1, 1, OVERFLOW_RESULT);
		add_row(4'd15, 25'h1FFFFFF, 6'd63, 1, 1, OVERFLOW_RESULT);
		// ties on size, key and tag, including an exact duplicate
		add_row(4'd3, 25'd5, 6'd1, 0, 0, '0);
		add_row(4'd3, 25'd5, 6'd2, 0, 0, '0);
		add_row(4'd2, 25'd9, 6'd7, 0, 0, '0);
		add_row(4'd2, 25'd9, 6'd7, 0, 0, '0);
		add_row(4'd2, 25'd0, 6'd63, 0, 0, '0);
		add_row(4'd1, 25'h1FFFFFF, 6'd0, 1, 0, '0);
		// two full-size tiles, and a full-size tile plus one pixel: both overflow
		add_row(4'd12, 25'd0, 6'd1, 0, 0, '0);
		add_row(4'd12, 25'd0, 6'd2, 1, 1, OVERFLOW_RESULT);
		add_row(4'd12, 25'd7, 6'd3, 0, 0, '0);
		add_row(4'd0, 25'd7, 6'd4, 1, 1, OVERFLOW_RESULT);
		// four quarter tiles fill the capacity exactly
		add_row(4'd11, 25'd3, 6'd10, 0, 0, '0);
		add_row(4'd11, 25'd3, 6'd11, 0, 0, '0);
		add_row(4'd11, 25'd1, 6'd12, 0, 0, '0);
		add_row(4'd11, 25'd7, 6'd13, 1, 0, '0);
		add_row(4'd4, 25'h0AAAAAA, 6'd42, 0, 0, '0);
		add_row(4'd1, 25'h1FFFFFF, 6'd21, 0, 0, '0);
		add_row(4'd6, 25'h1555555, 6'd62, 1, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			feed_tile(directed[i].tile, directed[i].fin,
				($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14),
				directed[i].typed, directed[i].want);

		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			case (phase)
				0: cfg = 4'd15;
				1: cfg = 4'd0;
				2: cfg = 4'd2;
				3: cfg = 4'd12;
				default: cfg = 4'($urandom_range(0, 15));
			endcase
			program_max_side(cfg);
			eff = (cfg > MAX_SIDE_LOG2_DEF) ? MAX_SIDE_LOG2_DEF : cfg;
			phase_items = 0;
			while (phase_items < 18) begin
				burst = ($urandom_range(0, 3) == 0);
				// big sets of 64 to 68 tiles fill or overfill the tile store; phase 3 always opens with one
				big_set = (phase == 3 && phase_items == 0) || ($urandom_range(0, 29) == 0);
				n = big_set ? $urandom_range(64, 68) : $urandom_range(1, 10);
				if (big_set)
					smax = (eff < 3) ? eff : 3;
				else if ($urandom_range(0, 3) == 0)
					smax = eff;
				else
					smax = (eff >= 2) ? eff - 2 : 0;
				for (int k = 0; k < n; k++) begin
					t.size = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(0, smax));
					t.key = ($urandom_range(0, 2) == 0) ? 25'($urandom_range(0, 3))
						: 25'($urandom);
					t.tag = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 3))
						: 6'($urandom_range(0, 63));
					feed_tile(t, k == n - 1, burst ? 0 : $urandom_range(0, 14), 0, '0);
				end
				phase_items += n;
			end
		end

		start <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("morton_square_atlas_packer verification clean");
		else
			$display("morton_square_atlas_packer verification failed");
		$finish;
	end
endmodule
`default_nettype wire
